>>> hdl/bcm_pkg.sv
`timescale 1ns / 1ps

package bcm_pkg;

    // Modulus and the Fermat exponent used for the inverse
    localparam logic [29:0] PRIME      = 30'd998244353;
    localparam logic [29:0] FERMAT_EXP = PRIME - 30'd2;
    localparam logic [31:0] TWO_PRIME  = {1'b0, PRIME, 1'b0};

    // Barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] BARRETT_MU_FULL = (64'd1 << 60) / {34'd0, PRIME};
    localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

    typedef logic [4:0] t_step;

    // Microprogram addresses
    localparam t_step STEP_IDLE       = 5'd0;
    localparam t_step STEP_CHECK      = 5'd1;
    localparam t_step STEP_CHECK_ZERO = 5'd2;
    localparam t_step STEP_NMOD       = 5'd3;
    localparam t_step STEP_NMOD_WAIT  = 5'd4;
    localparam t_step STEP_LOOP_NA    = 5'd5;
    localparam t_step STEP_LOOP_DA    = 5'd6;
    localparam t_step STEP_LOOP_NB    = 5'd7;
    localparam t_step STEP_LOOP_DB    = 5'd8;
    localparam t_step STEP_LOOP_WAIT  = 5'd9;
    localparam t_step STEP_MERGE_N    = 5'd10;
    localparam t_step STEP_MERGE_D    = 5'd11;
    localparam t_step STEP_MERGE_WAIT = 5'd12;
    localparam t_step STEP_POW_MUL    = 5'd13;
    localparam t_step STEP_POW_SQR    = 5'd14;
    localparam t_step STEP_POW_WAIT   = 5'd15;
    localparam t_step STEP_POW_TEST   = 5'd16;
    localparam t_step STEP_FINAL      = 5'd17;
    localparam t_step STEP_FINAL_WAIT = 5'd18;
    localparam t_step STEP_EMIT       = 5'd19;
    localparam t_step STEP_RETURN     = 5'd20;
    localparam t_step STEP_ZERO       = 5'd21;
    localparam t_step STEP_ONE        = 5'd22;

    // Multiplier operand sources
    typedef enum logic [3:0] {
        SRC_ONE,
        SRC_N,
        SRC_NA,
        SRC_NB,
        SRC_DA,
        SRC_DB,
        SRC_TN0,
        SRC_TD0,
        SRC_TN1,
        SRC_TD1
    } t_src;

    // Multiplier result destinations
    typedef enum logic [2:0] {
        DST_NM,
        DST_NA,
        DST_NB,
        DST_DA,
        DST_DB,
        DST_RES
    } t_dst;

    typedef enum logic [1:0] {
        MUL_OFF,
        MUL_ON,
        MUL_IF_EBIT
    } t_mul;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_OUT_RANGE,
        COND_R_ZERO,
        COND_BUSY,
        COND_MORE_PAIRS,
        COND_EXP_MORE,
        COND_OUT_FULL
    } t_cond;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_INIT,
        ACT_STEP_I,
        ACT_EXP_INIT,
        ACT_EXP_SHIFT,
        ACT_SET_ZERO,
        ACT_SET_ONE,
        ACT_EMIT
    } t_act;

    // One control word of the microprogram
    typedef struct packed {
        t_src  src_a;
        t_src  src_b;
        t_mul  mul;
        t_dst  dst;
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    // Datapath flags for conditional jumps
    typedef struct packed {
        logic out_range;
        logic r_zero;
        logic busy;
        logic more_pairs;
        logic exp_more;
    } t_status;

    function automatic t_uword uw(input t_src a, input t_src b, input t_mul m,
                                  input t_dst d, input t_act act, input t_cond c,
                                  input t_step tgt);
        t_uword w;
        w.src_a  = a;
        w.src_b  = b;
        w.mul    = m;
        w.dst    = d;
        w.act    = act;
        w.cond   = c;
        w.target = tgt;
        return w;
    endfunction

    // Microprogram ROM
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_LOAD, COND_NO_INPUT, STEP_IDLE);
            STEP_CHECK:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_OUT_RANGE, STEP_ZERO);
            STEP_CHECK_ZERO:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_R_ZERO, STEP_ONE);
            STEP_NMOD:
                w = uw(SRC_N, SRC_ONE, MUL_ON, DST_NM, ACT_INIT, COND_NEXT, STEP_IDLE);
            STEP_NMOD_WAIT:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_BUSY, STEP_NMOD_WAIT);
            STEP_LOOP_NA:
                w = uw(SRC_NA, SRC_TN0, MUL_ON, DST_NA, ACT_NONE, COND_NEXT, STEP_IDLE);
            STEP_LOOP_DA:
                w = uw(SRC_DA, SRC_TD0, MUL_ON, DST_DA, ACT_NONE, COND_NEXT, STEP_IDLE);
            STEP_LOOP_NB:
                w = uw(SRC_NB, SRC_TN1, MUL_ON, DST_NB, ACT_NONE, COND_NEXT, STEP_IDLE);
            STEP_LOOP_DB:
                w = uw(SRC_DB, SRC_TD1, MUL_ON, DST_DB, ACT_STEP_I, COND_MORE_PAIRS,
                       STEP_LOOP_NA);
            STEP_LOOP_WAIT:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_BUSY, STEP_LOOP_WAIT);
            STEP_MERGE_N:
                w = uw(SRC_NA, SRC_NB, MUL_ON, DST_NA, ACT_NONE, COND_NEXT, STEP_IDLE);
            STEP_MERGE_D:
                w = uw(SRC_DA, SRC_DB, MUL_ON, DST_DA, ACT_EXP_INIT, COND_NEXT, STEP_IDLE);
            STEP_MERGE_WAIT:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_BUSY, STEP_MERGE_WAIT);
            STEP_POW_MUL:
                w = uw(SRC_NB, SRC_DA, MUL_IF_EBIT, DST_NB, ACT_NONE, COND_NEXT, STEP_IDLE);
            STEP_POW_SQR:
                w = uw(SRC_DA, SRC_DA, MUL_ON, DST_DA, ACT_EXP_SHIFT, COND_NEXT, STEP_IDLE);
            STEP_POW_WAIT:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_BUSY, STEP_POW_WAIT);
            STEP_POW_TEST:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_EXP_MORE, STEP_POW_MUL);
            STEP_FINAL:
                w = uw(SRC_NA, SRC_NB, MUL_ON, DST_RES, ACT_NONE, COND_NEXT, STEP_IDLE);
            STEP_FINAL_WAIT:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_BUSY, STEP_FINAL_WAIT);
            STEP_EMIT:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_EMIT, COND_OUT_FULL, STEP_EMIT);
            STEP_RETURN:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_ALWAYS, STEP_IDLE);
            STEP_ZERO:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_SET_ZERO, COND_ALWAYS, STEP_EMIT);
            STEP_ONE:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_SET_ONE, COND_ALWAYS, STEP_EMIT);
            default:
                w = uw(SRC_ONE, SRC_ONE, MUL_OFF, DST_NM, ACT_NONE, COND_ALWAYS, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

>>> hdl/bcm_modmul.sv
`timescale 1ns / 1ps

// Pipelined modular multiplier: a*b mod p with Barrett reduction.
// Issue one product per cycle; stages r_x, r_q/r_xlo, r_rem.
module bcm_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bcm_pkg::t_dst     i_dst,
    input  logic [31:0]       i_a,
    input  logic [29:0]       i_b,
    output logic              o_busy,
    output logic              o_valid,
    output bcm_pkg::t_dst     o_dst,
    output logic [29:0]       o_res
);

    logic          r_v1, r_v2, r_v3;
    bcm_pkg::t_dst r_d1, r_d2, r_d3;
    logic [59:0]   r_x;
    logic [30:0]   r_q;
    logic [31:0]   r_xlo;
    logic [31:0]   r_rem;

    logic [61:0]   prod;
    logic [61:0]   qprod;
    logic [60:0]   qp;
    logic [32:0]   sub1;
    logic [32:0]   sub2;

    // Full product, then quotient estimate, then remainder below 3p
    assign prod  = i_a * i_b;
    assign qprod = r_x[59:29] * bcm_pkg::BARRETT_MU;
    assign qp    = r_q * bcm_pkg::PRIME;

    always_ff @(posedge i_clk) begin
        r_x   <= prod[59:0];
        r_q   <= qprod[61:31];
        r_xlo <= r_x[31:0];
        r_rem <= r_xlo - qp[31:0];
        r_d1  <= i_dst;
        r_d2  <= r_d1;
        r_d3  <= r_d2;
    end

    // Advance the valid tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Final correction: drop p or 2p
    assign sub2 = {1'b0, r_rem} - {1'b0, bcm_pkg::TWO_PRIME};
    assign sub1 = {1'b0, r_rem} - {3'd0, bcm_pkg::PRIME};

    always_comb begin
        if (!sub2[32]) begin
            o_res = sub2[29:0];
        end else if (!sub1[32]) begin
            o_res = sub1[29:0];
        end else begin
            o_res = r_rem[29:0];
        end
    end

    assign o_valid = r_v3;
    assign o_dst   = r_d3;
    assign o_busy  = r_v1 | r_v2 | r_v3;

    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> $past(i_valid, 3))
        else $error("modmul result without matching issue");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res < bcm_pkg::PRIME))
        else $error("modmul result not reduced");

endmodule

>>> hdl/bcm_datapath.sv
`timescale 1ns / 1ps

// Operand registers, loop index, exponent and the shared modular multiplier
module bcm_datapath #(
    parameter int unsigned MAX_CHOOSE = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcm_pkg::t_uword   i_ctl,
    input  logic              i_in_valid,
    input  logic [31:0]       i_top_count,
    input  logic [15:0]       i_choose_count,
    output bcm_pkg::t_status  o_stat,
    output logic [29:0]       o_res
);

    logic [31:0] r_n;
    logic [15:0] r_r;
    logic [15:0] r_i;
    logic [29:0] r_nm, r_na, r_nb, r_da, r_db, r_res;
    logic [29:0] r_exp;

    logic [16:0] i1, i2;
    logic [30:0] d0, d1;
    logic [29:0] tn0, tn1, td0, td1;
    logic        second_ok;
    logic [31:0] op_a, op_b;
    logic        mul_en;
    logic        mm_busy, mm_valid;
    bcm_pkg::t_dst mm_dst;
    logic [29:0] mm_res;

    // Falling-product and factorial terms for index i and i+1
    assign i1        = 17'(r_i) + 17'd1;
    assign i2        = 17'(r_i) + 17'd2;
    assign d0        = {1'b0, r_nm} - 31'(r_i);
    assign d1        = {1'b0, r_nm} - 31'(i1);
    assign second_ok = i1 < 17'(r_r);

    always_comb begin
        logic [30:0] w0, w1;
        w0  = d0 + {1'b0, bcm_pkg::PRIME};
        w1  = d1 + {1'b0, bcm_pkg::PRIME};
        tn0 = d0[30] ? w0[29:0] : d0[29:0];
        tn1 = !second_ok ? 30'd1 : (d1[30] ? w1[29:0] : d1[29:0]);
        td0 = 30'(i1);
        td1 = second_ok ? 30'(i2) : 30'd1;
    end

    function automatic logic [31:0] operand(input bcm_pkg::t_src s);
        logic [31:0] v;
        case (s)
            bcm_pkg::SRC_ONE: v = 32'd1;
            bcm_pkg::SRC_N:   v = r_n;
            bcm_pkg::SRC_NA:  v = {2'd0, r_na};
            bcm_pkg::SRC_NB:  v = {2'd0, r_nb};
            bcm_pkg::SRC_DA:  v = {2'd0, r_da};
            bcm_pkg::SRC_DB:  v = {2'd0, r_db};
            bcm_pkg::SRC_TN0: v = {2'd0, tn0};
            bcm_pkg::SRC_TD0: v = {2'd0, td0};
            bcm_pkg::SRC_TN1: v = {2'd0, tn1};
            bcm_pkg::SRC_TD1: v = {2'd0, td1};
            default:          v = 32'd1;
        endcase
        return v;
    endfunction

    // Select operands and gate the issue
    always_comb begin
        op_a = operand(i_ctl.src_a);
        op_b = operand(i_ctl.src_b);
    end

    assign mul_en = (i_ctl.mul == bcm_pkg::MUL_ON) ||
                    ((i_ctl.mul == bcm_pkg::MUL_IF_EBIT) && r_exp[0]);

    bcm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_en),
        .i_dst   (i_ctl.dst),
        .i_a     (op_a),
        .i_b     (op_b[29:0]),
        .o_busy  (mm_busy),
        .o_valid (mm_valid),
        .o_dst   (mm_dst),
        .o_res   (mm_res)
    );

    // Apply step actions, then write back multiplier results
    always_ff @(posedge i_clk) begin
        case (i_ctl.act)
            bcm_pkg::ACT_LOAD: begin
                if (i_in_valid) begin
                    r_n <= i_top_count;
                    r_r <= i_choose_count;
                end
            end
            bcm_pkg::ACT_INIT: begin
                r_na <= 30'd1;
                r_nb <= 30'd1;
                r_da <= 30'd1;
                r_db <= 30'd1;
                r_i  <= '0;
            end
            bcm_pkg::ACT_STEP_I: begin
                r_i <= r_i + 16'd2;
            end
            bcm_pkg::ACT_EXP_INIT: begin
                r_nb  <= 30'd1;
                r_exp <= bcm_pkg::FERMAT_EXP;
            end
            bcm_pkg::ACT_EXP_SHIFT: begin
                r_exp <= r_exp >> 1;
            end
            bcm_pkg::ACT_SET_ZERO: begin
                r_res <= 30'd0;
            end
            bcm_pkg::ACT_SET_ONE: begin
                r_res <= 30'd1;
            end
            default: begin
            end
        endcase
        if (mm_valid) begin
            case (mm_dst)
                bcm_pkg::DST_NM:  r_nm  <= mm_res;
                bcm_pkg::DST_NA:  r_na  <= mm_res;
                bcm_pkg::DST_NB:  r_nb  <= mm_res;
                bcm_pkg::DST_DA:  r_da  <= mm_res;
                bcm_pkg::DST_DB:  r_db  <= mm_res;
                bcm_pkg::DST_RES: r_res <= mm_res;
                default: begin
                end
            endcase
        end
    end

    // Flags for the sequencer
    assign o_stat.out_range  = (r_n < 32'(r_r)) || (32'(r_r) > 32'(MAX_CHOOSE));
    assign o_stat.r_zero     = (r_r == 16'd0);
    assign o_stat.busy       = mm_busy;
    assign o_stat.more_pairs = i2 < 17'(r_r);
    assign o_stat.exp_more   = (r_exp != 30'd0);
    assign o_res             = r_res;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.act == bcm_pkg::ACT_LOAD) |-> !mm_busy)
        else $error("multiplier still busy at idle step");

endmodule

>>> hdl/bcm_sequencer.sv
`timescale 1ns / 1ps

// Step counter over the microprogram ROM with conditional jumps
module bcm_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_full,
    input  bcm_pkg::t_status  i_stat,
    output bcm_pkg::t_uword   o_ctl
);

    bcm_pkg::t_step  r_pc;
    bcm_pkg::t_step  n_pc;
    bcm_pkg::t_uword w;
    logic            take;

    assign w     = bcm_pkg::ucode(r_pc);
    assign o_ctl = w;

    // Evaluate the jump condition
    always_comb begin
        unique case (w.cond)
            bcm_pkg::COND_NEXT:       take = 1'b0;
            bcm_pkg::COND_ALWAYS:     take = 1'b1;
            bcm_pkg::COND_NO_INPUT:   take = !i_in_valid;
            bcm_pkg::COND_OUT_RANGE:  take = i_stat.out_range;
            bcm_pkg::COND_R_ZERO:     take = i_stat.r_zero;
            bcm_pkg::COND_BUSY:       take = i_stat.busy;
            bcm_pkg::COND_MORE_PAIRS: take = i_stat.more_pairs;
            bcm_pkg::COND_EXP_MORE:   take = i_stat.exp_more;
            bcm_pkg::COND_OUT_FULL:   take = i_out_full;
            default:                  take = 1'b1;
        endcase
        n_pc = take ? w.target : r_pc + bcm_pkg::t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bcm_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> hdl/binomial_coefficient_mod_prime_unit.sv
`timescale 1ns / 1ps

// Binomial coefficient C(n, r) modulo 998244353.
// Input channel: i_in_valid / o_in_stall carry n (i_top_count) and r
// (i_choose_count); a beat is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry one result beat per input.
// n < r, or r above MAX_CHOOSE, gives 0 and r = 0 gives 1; neither case uses
// the multiplier, and the next beat is taken once the result is emitted and
// the sequencer is back at its idle step.
// Otherwise a microcoded sequencer drives one shared three-stage modular
// multiplier that accepts one product per cycle; four interleaved product
// chains keep it busy in the main loop, the sequencer waits for each drain
// of the multiplier, and the Fermat inverse adds 30 square-and-multiply
// rounds.
// One item is worked on at a time; o_in_stall is low only between items.
// The result sits in an output register, so the next item is accepted while
// a stalled result waits; a new result is held back until that one is taken.
// Reset (synchronous, active low) returns the sequencer to its idle step and
// empties the output register.
module binomial_coefficient_mod_prime_unit #(
    parameter int unsigned MAX_CHOOSE = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_top_count,
    input  logic [15:0] i_choose_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [29:0] o_binomial_value
);

    bcm_pkg::t_uword  ctl;
    bcm_pkg::t_status stat;
    logic [29:0]      res;
    logic             out_full;
    logic             emit;
    logic             r_out_valid;
    logic [29:0]      r_out_data;

    bcm_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_full (out_full),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    bcm_datapath #(
        .MAX_CHOOSE (MAX_CHOOSE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_in_valid     (i_in_valid),
        .i_top_count    (i_top_count),
        .i_choose_count (i_choose_count),
        .o_stat         (stat),
        .o_res          (res)
    );

    // Take a beat only at the idle step
    assign o_in_stall = (ctl.act != bcm_pkg::ACT_LOAD);

    // Hold the result until the receiver takes it
    assign out_full = r_out_valid & i_out_stall;
    assign emit     = (ctl.act == bcm_pkg::ACT_EMIT) && !out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_binomial_value = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat taken while an item is in work");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_binomial_value < bcm_pkg::PRIME))
        else $error("result not below the modulus");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_out_data) && r_out_valid))
        else $error("waiting result overwritten");

endmodule
